>>> rtl/kct_pkg.sv
// shared constants and codes for the keyed count table
package kct_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 16;

    // fixed field widths of the stream payload
    localparam int KEY_FIELD_W = 16;
    localparam int CNT_W       = 64;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 72;

    // action codes
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUB   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

endpackage

>>> rtl/kct_ram.sv
// generic simple dual-port ram with registered read
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/keyed_count_table_unit.sv
// keyed count table: bounded key to signed count map held in two rams
// steps: query, set, add and subtract probe the key ram linearly, one entry a cycle, then fetch
//   the count, compute, and write back while handing over the result; clear sweeps the key ram
// flow: one transaction in flight; a new one is taken only once the last has handed over its result
// reset: synchronous active low; afterwards a sweep of the key ram marks every key slot free,
//   and no input transaction is taken until it ends
module keyed_count_table_unit #(
    parameter int ENTRIES  = kct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kct_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [kct_pkg::IN_DATA_W-1:0]  i_s_tdata,  // key[15:0], amount[79:16], min_amount[143:80]
    input  logic [kct_pkg::ACT_W-1:0]      i_s_tuser,  // action[2:0]
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [kct_pkg::OUT_DATA_W-1:0] o_m_tdata   // count[63:0], meets_minimum[64],
                                                       // status[66:65], zero pad[71:67]
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int KW    = KEY_BITS + 1;  // stored key word: valid bit on top
    localparam int CW    = kct_pkg::CNT_W;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,  // clear pass over the key ram
        S_SCAN  = 6'b000100,  // probe every slot for the key and the first free slot
        S_FETCH = 6'b001000,  // read the count of the hit slot
        S_CALC  = 6'b010000,  // arithmetic and write decision
        S_WRITE = 6'b100000   // write back and hand over the result
    } t_state;

    t_state r_state, n_state;
    logic   r_init, n_init;

    // captured transaction
    logic [kct_pkg::ACT_W-1:0] r_action;
    logic [KEY_BITS-1:0]       r_key;
    logic [CW-1:0]             r_amt;
    logic [CW-1:0]             r_min;

    // probe bookkeeping
    logic [AW-1:0] r_addr, n_addr;
    logic          r_issued, n_issued;
    logic          r_pend, n_pend;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic          r_free, n_free;
    logic [AW-1:0] r_free_idx, n_free_idx;

    // write back plan and result
    logic                       r_wk_en, n_wk_en;
    logic [KW-1:0]              r_wk_data, n_wk_data;
    logic                       r_wc_en, n_wc_en;
    logic [AW-1:0]              r_w_idx, n_w_idx;
    logic [CW-1:0]              r_res_cnt, n_res_cnt;
    logic [kct_pkg::STAT_W-1:0] r_res_stat, n_res_stat;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [kct_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // ram ports
    logic          key_we;
    logic [AW-1:0] key_waddr;
    logic [KW-1:0] key_wdata;
    logic [KW-1:0] key_rdata;
    logic          cnt_we;
    logic [CW-1:0] cnt_rdata;

    // input field views
    logic                    s_accept;
    logic [31:0]             in_key_ext;
    logic [KEY_BITS-1:0]     in_key;
    logic                    slot_match;
    logic                    slot_empty;
    logic                    out_free;

    // arithmetic in calc
    logic [CW-1:0] old_cnt;
    logic [CW-1:0] addend;
    logic [CW-1:0] sum;
    logic          is_sub;
    logic          ovf;
    logic [CW-1:0] new_val;
    logic          modify;
    logic          meets;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_key_ext = 32'(i_s_tdata[kct_pkg::KEY_FIELD_W-1:0]);
    assign in_key     = in_key_ext[KEY_BITS-1:0];
    assign out_free   = !r_out_valid || i_m_tready;

    assign slot_empty = !key_rdata[KEY_BITS];
    assign slot_match = key_rdata[KEY_BITS] && (key_rdata[KEY_BITS-1:0] == r_key);

    // key store: valid bit and key per slot
    kct_ram #(
        .WIDTH (KW),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_addr),
        .o_rdata (key_rdata)
    );

    // count store, read only at the hit slot
    kct_ram #(
        .WIDTH (CW),
        .DEPTH (ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_w_idx),
        .i_wdata (r_res_cnt),
        .i_raddr (r_hit_idx),
        .o_rdata (cnt_rdata)
    );

    // sweep clears slots; write back stores the planned key word
    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_w_idx;
        key_wdata = r_wk_data;
        cnt_we    = 1'b0;
        if (r_state == S_SWEEP) begin
            key_we    = 1'b1;
            key_waddr = r_addr;
            key_wdata = '0;
        end else if (r_state == S_WRITE && out_free) begin
            key_we = r_wk_en;
            cnt_we = r_wc_en;
        end
    end

    // saturating add or subtract on the old count
    always_comb begin
        old_cnt = r_hit ? cnt_rdata : '0;
        is_sub  = (r_action == kct_pkg::ACT_SUB);
        addend  = is_sub ? ~r_amt : r_amt;
        sum     = old_cnt + addend + CW'(is_sub);
        if (is_sub) begin
            ovf = (old_cnt[CW-1] ^ r_amt[CW-1]) && (old_cnt[CW-1] ^ sum[CW-1]);
        end else begin
            ovf = (old_cnt[CW-1] ^ sum[CW-1]) && (r_amt[CW-1] ^ sum[CW-1]);
        end
        case (r_action)
            kct_pkg::ACT_SET: begin
                new_val = r_amt;
                modify  = 1'b1;
            end
            kct_pkg::ACT_ADD, kct_pkg::ACT_SUB: begin
                if (ovf) begin
                    new_val = old_cnt[CW-1] ? kct_pkg::CNT_MIN : kct_pkg::CNT_MAX;
                end else begin
                    new_val = sum;
                end
                modify = 1'b1;
            end
            default: begin
                // query and unused codes leave the table alone
                new_val = old_cnt;
                modify  = 1'b0;
            end
        endcase
    end

    assign meets = ($signed(r_res_cnt) >= $signed(r_min));

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_wk_en     = r_wk_en;
        n_wk_data   = r_wk_data;
        n_wc_en     = r_wc_en;
        n_w_idx     = r_w_idx;
        n_res_cnt   = r_res_cnt;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_addr     = '0;
                    n_issued   = 1'b0;
                    n_pend     = 1'b0;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_wk_en    = 1'b0;
                    n_wc_en    = 1'b0;
                    n_res_cnt  = '0;
                    n_res_stat = kct_pkg::ST_OK;
                    if (i_s_tuser == kct_pkg::ACT_CLEAR) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SWEEP: begin
                if (r_addr == LAST) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_WRITE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SCAN: begin
                // address issue runs ahead of the compare: each slot is compared in the cycle after its address
                n_pend = !r_issued;
                if (!r_issued) begin
                    if (r_addr == LAST) begin
                        n_issued = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (slot_match) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_addr - AW'(!r_issued);
                    end
                    if (slot_empty && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_addr - AW'(!r_issued);
                    end
                end
                if (r_issued && !r_pend) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_res_cnt  = new_val;
                n_res_stat = kct_pkg::ST_OK;
                n_wk_en    = 1'b0;
                n_wc_en    = 1'b0;
                n_w_idx    = r_hit_idx;
                if (modify) begin
                    if (new_val == '0) begin
                        // zero frees the slot, or creates nothing on a miss
                        n_wk_en   = r_hit;
                        n_wk_data = '0;
                    end else if (r_hit) begin
                        n_wc_en = 1'b1;
                        if (ovf && r_action != kct_pkg::ACT_SET) begin
                            n_res_stat = kct_pkg::ST_OVF;
                        end
                    end else if (r_free) begin
                        n_wk_en   = 1'b1;
                        n_wk_data = {1'b1, r_key};
                        n_wc_en   = 1'b1;
                        n_w_idx   = r_free_idx;
                        if (ovf && r_action != kct_pkg::ACT_SET) begin
                            n_res_stat = kct_pkg::ST_OVF;
                        end
                    end else begin
                        // new key with no free slot: dropped
                        n_res_cnt  = '0;
                        n_res_stat = kct_pkg::ST_FULL;
                    end
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // write back and result hand-over happen in the same cycle
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, r_res_stat, meets, r_res_cnt};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_issued    <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_wk_en     <= 1'b0;
            r_wc_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_wk_en     <= n_wk_en;
            r_wc_en     <= n_wc_en;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action <= i_s_tuser;
            r_key    <= in_key;
            r_amt    <= i_s_tdata[79:16];
            r_min    <= i_s_tdata[143:80];
        end
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_wk_data  <= n_wk_data;
        r_w_idx    <= n_w_idx;
        r_res_cnt  <= n_res_cnt;
        r_res_stat <= n_res_stat;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> sim/keyed_count_table_checker.sv
// checker for the keyed count table: predicts each result and compares the result stream
`timescale 1ns / 1ps

module keyed_count_table_checker
    import kct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // key[15:0], amount[79:16], min_amount[143:80]
    input  logic [ACT_W-1:0]      i_s_tuser,  // action[2:0]
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,  // count[63:0], meets_minimum[64], status[66:65]
    output int                    o_fail_count,
    output int                    o_open_count
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              meets_min;
        logic [STAT_W-1:0] status;
    } tally_t;

    tally_t tally_q[$];

    // shadow copy of the table
    logic                   slot_used  [ENTRIES];
    logic [KEY_FIELD_W-1:0] slot_key   [ENTRIES];
    logic [CNT_W-1:0]       slot_count [ENTRIES];

    int fail_n = 0;
    int open_n = 0;

    assign o_fail_count = fail_n;
    assign o_open_count = open_n;

    task automatic note_mismatch(input string what);
        if (fail_n < MAX_PRINTED) $display("mismatch: %s", what);
        fail_n++;
    endtask

    // applies one action to the shadow table and returns the result it should give
    function automatic tally_t apply_to_table(input logic [ACT_W-1:0] action,
                                              input logic [KEY_FIELD_W-1:0] key,
                                              input logic [CNT_W-1:0] amount,
                                              input logic [CNT_W-1:0] min_amount);
        int               hit;
        int               vacant;
        logic [CNT_W-1:0] held;
        logic [CNT_W-1:0] next;
        logic [CNT_W:0]   wide;
        logic             ovf;
        logic             writes;
        tally_t           res;
        hit    = -1;
        vacant = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
            if (!slot_used[i] && vacant < 0) vacant = i;
        end
        held       = (hit >= 0) ? slot_count[hit] : '0;
        next       = held;
        ovf        = 1'b0;
        writes     = 1'b0;
        res.count  = held;
        res.status = ST_OK;
        case (action)
            ACT_SET: begin
                next   = amount;
                writes = 1'b1;
            end
            ACT_ADD, ACT_SUB: begin
                if (action == ACT_ADD) wide = {held[CNT_W-1], held} + {amount[CNT_W-1], amount};
                else                   wide = {held[CNT_W-1], held} - {amount[CNT_W-1], amount};
                ovf    = wide[CNT_W] != wide[CNT_W-1];
                next   = ovf ? (held[CNT_W-1] ? CNT_MIN : CNT_MAX) : wide[CNT_W-1:0];
                writes = 1'b1;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
                res.count = '0;
            end
            default: ;  // query and spare codes leave the table alone
        endcase
        if (writes) begin
            if (next == '0) begin
                // zero frees the entry, or creates nothing on a miss
                if (hit >= 0) slot_used[hit] = 1'b0;
                res.count = '0;
            end else if (hit >= 0 || vacant >= 0) begin
                if (hit < 0) begin
                    hit            = vacant;
                    slot_used[hit] = 1'b1;
                    slot_key[hit]  = key;
                end
                slot_count[hit] = next;
                res.count       = next;
                res.status      = ovf ? ST_OVF : ST_OK;
            end else begin
                // new key with no free slot: dropped
                res.count  = '0;
                res.status = ST_FULL;
            end
        end
        res.meets_min = $signed(res.count) >= $signed(min_amount);
        return res;
    endfunction

    initial begin
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
    end

    always @(posedge i_clk) begin : watch
        tally_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
            tally_q.delete();
        end else begin
            // results first: with one request in flight they belong to older requests
            if (i_m_tvalid && i_m_tready) begin
                if (tally_q.size() == 0) begin
                    note_mismatch($sformatf("result %h with nothing outstanding", i_m_tdata));
                end else begin
                    want = tally_q.pop_front();
                    if (i_m_tdata[CNT_W-1:0] !== want.count)
                        note_mismatch($sformatf("count %h, expected %h",
                                                i_m_tdata[CNT_W-1:0], want.count));
                    if (i_m_tdata[CNT_W] !== want.meets_min)
                        note_mismatch($sformatf("meets_minimum %b, expected %b",
                                                i_m_tdata[CNT_W], want.meets_min));
                    if (i_m_tdata[CNT_W+STAT_W:CNT_W+1] !== want.status)
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                i_m_tdata[CNT_W+STAT_W:CNT_W+1], want.status));
                end
            end
            if (i_s_tvalid && i_s_tready)
                tally_q.push_back(apply_to_table(
                    i_s_tuser,
                    i_s_tdata[KEY_FIELD_W-1:0],
                    i_s_tdata[KEY_FIELD_W+CNT_W-1:KEY_FIELD_W],
                    i_s_tdata[KEY_FIELD_W+2*CNT_W-1:KEY_FIELD_W+CNT_W]));
        end
        open_n = tally_q.size();
    end

endmodule

>>> sim/keyed_count_table_unit_test.sv
// testbench top for the keyed count table: stimulus, flow control and verdict
`timescale 1ns / 1ps

module keyed_count_table_unit_test;
    import kct_pkg::*;

    // spare action codes, handled by the block as a query
    localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    localparam int ITEM_GOAL    = 1900;
    localparam int DRAIN_CYCLES = ENTRIES_DEF + 20;  // probe latency plus margin
    localparam int LONG_HOLD    = 600;               // receiver hold-off that backs up the input

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // key, amount, min_amount from the low bits up
    logic [ACT_W-1:0]      s_tuser  = ACT_QUERY;  // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;  // count, meets_minimum, status, pad from the low bits up

    int fail_count;
    int open_count;
    int sent_total = 0;
    int burst_left = 1;

    always #1 clk = ~clk;

    keyed_count_table_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    keyed_count_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    // amounts and thresholds: small values so sums return to zero, the bounds and their
    // neighbors so sums saturate, and fully random words so every bit toggles
    function automatic logic [CNT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CNT_W'(signed'(32'($urandom_range(0, 8)) - 32'sd4));
            4: begin
                case ($urandom_range(0, 5))
                    0:       return CNT_MAX;
                    1:       return CNT_MIN;
                    2:       return CNT_MAX - 1;
                    3:       return CNT_MIN + 1;
                    4:       return '1;
                    default: return CNT_W'(1);
                endcase
            end
            5, 6:    return {$urandom, $urandom};
            7:       return CNT_MAX - CNT_W'($urandom_range(0, 3));
            8:       return CNT_MIN + CNT_W'($urandom_range(0, 3));
            default: return CNT_W'(signed'($urandom));
        endcase
    endfunction

    // one input transaction; tvalid stays high across a burst and drops only for a gap
    task automatic offer(input logic [ACT_W-1:0] act, input logic [KEY_FIELD_W-1:0] key,
                         input logic [CNT_W-1:0] amount, input logic [CNT_W-1:0] min_amt);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {min_amt, amount, key};
        do @(posedge clk); while (!s_tready);
        sent_total++;
        burst_left--;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 5);
                2:       gap = $urandom_range(6, 40);
                default: gap = $urandom_range(41, 100);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // receiver: open stretches, short and long stalls, and one long hold-off early on
    initial begin : result_sink
        int phase;
        int span;
        phase = 0;
        forever begin
            @(posedge clk);
            if (phase == 6) begin
                // the sender keeps offering, so the block backs up and drops tready
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) span = $urandom_range(50, 300);
            else span = $urandom_range(1, 30);
            repeat (span) @(posedge clk);
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
            phase++;
        end
    end

    initial begin : stimulus
        int                     pool_base;
        int                     pool_size;
        int                     span;
        int                     roll;
        logic [ACT_W-1:0]       act;
        logic [KEY_FIELD_W-1:0] key;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: absent keys, key extremes, saturation both ways, zero delta on a miss,
        // freeing by set and by sum, spare codes, clear
        offer(ACT_QUERY, 16'h0000, '0, '0);
        offer(ACT_QUERY, 16'hffff, '0, CNT_W'(1));
        offer(ACT_SET,   16'h0001, CNT_MAX, CNT_MAX);
        offer(ACT_ADD,   16'h0001, CNT_W'(1), CNT_MIN);
        offer(ACT_SUB,   16'h0002, CNT_MIN, CNT_MAX);
        offer(ACT_SET,   16'hffff, CNT_MIN, CNT_MIN);
        offer(ACT_SUB,   16'hffff, CNT_W'(1), CNT_MIN + 1);
        offer(ACT_ADD,   16'hffff, CNT_MIN, '0);
        offer(ACT_ADD,   16'h0004, '0, '0);
        offer(ACT_SUB,   16'h0004, '0, '1);
        offer(ACT_SET,   16'h0001, '0, '0);
        offer(ACT_QUERY, 16'h0001, '1, '0);
        offer(ACT_ADD,   16'h0005, CNT_W'(5), CNT_W'(5));
        offer(ACT_SUB,   16'h0005, CNT_W'(5), CNT_W'(6));
        offer(ACT_SPARE5, 16'h0002, CNT_W'(7), CNT_MAX);
        offer(ACT_SPARE6, 16'h0002, CNT_W'(7), '0);
        offer(ACT_SPARE7, 16'hffff, '1, CNT_MIN);
        offer(ACT_CLEAR, 16'h0002, CNT_MAX, '0);
        offer(ACT_QUERY, 16'h0002, '0, '0);
        offer(ACT_SET,   16'h0000, '1, CNT_MAX);

        // random: episodes that open with a clear and draw keys from a pool; pools larger
        // than the table fill it so new keys get dropped
        while (sent_total < ITEM_GOAL) begin
            pool_base = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0:       pool_size = 4;
                1:       pool_size = 40;
                2:       pool_size = 90;
                default: pool_size = 200;
            endcase
            span = $urandom_range(60, 300);
            offer(ACT_CLEAR, KEY_FIELD_W'($urandom), pick_amount(), pick_amount());
            for (int n = 0; n < span && sent_total < ITEM_GOAL; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 18)      act = ACT_QUERY;
                else if (roll < 38) act = ACT_SET;
                else if (roll < 66) act = ACT_ADD;
                else if (roll < 94) act = ACT_SUB;
                else if (roll < 99) act = ACT_SPARE5 + ACT_W'($urandom_range(0, 2));
                else                act = ACT_CLEAR;
                if ($urandom_range(0, 19) == 0) key = KEY_FIELD_W'($urandom);
                else key = KEY_FIELD_W'(pool_base + $urandom_range(0, pool_size - 1));
                offer(act, key, pick_amount(), pick_amount());
            end
        end
        s_tvalid <= 1'b0;

        // drain: every expected result, then a margin for anything stray
        while (open_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("keyed_count_table_unit_test OK");
        end else begin
            $display("keyed_count_table_unit_test NOT OK");
        end
        $finish;
    end

    // hard stop, several times the slowest expected run
    initial begin : watchdog
        #5_000_000;
        $display("keyed_count_table_unit_test NOT OK");
        $finish;
    end

endmodule

>>> keyed_count_table_unit.f
rtl/kct_pkg.sv
rtl/kct_ram.sv
rtl/keyed_count_table_unit.sv
sim/keyed_count_table_checker.sv
sim/keyed_count_table_unit_test.sv
